@@ hdl/stmc_pkg.sv @@
// shared types and constants for the coo mttkrp engine
package stmc_pkg;

  // item kinds
  localparam logic [1:0] KIND_WRITE = 2'd0;
  localparam logic [1:0] KIND_NZ    = 2'd1;
  localparam logic [1:0] KIND_READ  = 2'd2;

  // configuration register indexes
  localparam logic [1:0] REG_MODES  = 2'd0;
  localparam logic [1:0] REG_RANK   = 2'd1;
  localparam logic [1:0] REG_TARGET = 2'd2;

  // result kinds
  localparam logic RES_READ = 1'b0;
  localparam logic RES_DONE = 1'b1;

  localparam int COORD_FIELDS = 4;
  localparam int CW = 10;

  // classified item handed from front to back
  typedef struct packed {
    logic [1:0]  kind;
    logic [31:0] value;
    logic [CW-1:0] coord0;
    logic [CW-1:0] coord1;
    logic [CW-1:0] coord2;
    logic [CW-1:0] coord3;
    logic        last;
    logic        mode_ok;
    logic [1:0]  emode;
    logic [CW-1:0] erow;
    logic [3:0]  ecol;
  } cmd_t;

  // 32-bit saturation of a 34-bit value
  function automatic logic [31:0] sat34(input logic signed [33:0] v);
    logic [31:0] r;
    if (v > 34'sh07FFFFFFF) r = 32'h7FFFFFFF;
    else if (v < -34'sh080000000) r = 32'h80000000;
    else r = v[31:0];
    return r;
  endfunction

endpackage

@@ hdl/stmc_ram.sv @@
// generic single-port ram with registered read
module stmc_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) mem[addr] <= wdata;
    rdata <= mem[addr];
  end
endmodule

@@ hdl/stmc_front.sv @@
// front end: accepts items, classifies them and queues commands
module stmc_front #(
  parameter int MAX_MODES = 4,
  parameter int DEPTH = 2
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  stmc_pkg::cmd_t    in_cmd,
  output logic              q_valid,
  input  logic              q_pop,
  output stmc_pkg::cmd_t    q_cmd
);
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  stmc_pkg::cmd_t   fifo_r [DEPTH];
  logic [AW-1:0]    wp_r, wp_nxt, rp_r, rp_nxt;
  logic [AW:0]      cnt_r, cnt_nxt;
  logic             push;
  stmc_pkg::cmd_t   cls;

  // classify: flag element modes beyond the store, drop unused kinds
  always_comb begin
    cls = in_cmd;
    cls.mode_ok = ({30'd0, in_cmd.emode} < MAX_MODES);
  end

  assign in_ready = (cnt_r != DEPTH[AW:0]);
  assign push = in_valid && in_ready && (in_cmd.kind != 2'd3);
  assign q_valid = (cnt_r != '0);
  assign q_cmd = fifo_r[rp_r];

  // pointer update
  always_comb begin
    wp_nxt = wp_r;
    rp_nxt = rp_r;
    if (push) wp_nxt = (wp_r == AW'(DEPTH - 1)) ? '0 : wp_r + 1'b1;
    if (q_pop) rp_nxt = (rp_r == AW'(DEPTH - 1)) ? '0 : rp_r + 1'b1;
    cnt_nxt = cnt_r + {{AW{1'b0}}, push} - {{AW{1'b0}}, q_pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r <= '0;
      rp_r <= '0;
      cnt_r <= '0;
    end else begin
      wp_r <= wp_nxt;
      rp_r <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  // queue storage
  always_ff @(posedge clk) begin
    if (push) fifo_r[wp_r] <= cls;
  end
endmodule

@@ hdl/stmc_back.sv @@
// back end: element access and the per-rank multiply-accumulate sequencer
module stmc_back #(
  parameter int MAX_MODES = 4,
  parameter int MAX_RANK = 16,
  parameter int MAX_DIM = 1024
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              q_valid,
  output logic              q_pop,
  input  stmc_pkg::cmd_t    q_cmd,
  input  logic [2:0]        modes_in_use,
  input  logic [4:0]        rank_in_use,
  input  logic [1:0]        target_mode,
  output logic              out_valid,
  input  logic              out_ready,
  output logic              out_result_kind,
  output logic signed [31:0] out_read_value
);
  localparam int MW = (MAX_MODES > 1) ? $clog2(MAX_MODES) : 1;
  localparam int RW = (MAX_RANK > 1) ? $clog2(MAX_RANK) : 1;
  localparam int DW = $clog2(MAX_DIM);
  localparam int AW = MW + DW + RW;
  localparam int CAP = (MAX_MODES < 4) ? MAX_MODES : 4;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_RWAIT = 3'd1;
  localparam logic [2:0] S_RDATA = 3'd2;
  localparam logic [2:0] S_FRD = 3'd3;
  localparam logic [2:0] S_FMUL = 3'd4;
  localparam logic [2:0] S_FSH = 3'd5;
  localparam logic [2:0] S_ACC = 3'd6;
  localparam logic [2:0] S_WB = 3'd7;

  logic [2:0]  st_r, st_nxt;
  stmc_pkg::cmd_t cmd_r;
  logic [2:0]  m_r, m_nxt;
  logic [RW:0] r_r, r_nxt;
  logic [31:0] acc_r, acc_nxt;
  logic signed [63:0] prod_r;
  logic [2:0]  nm;
  logic [RW:0] rk;
  logic        ov;
  logic [31:0] sh;
  logic signed [63:0] p_hi;

  logic          we;
  logic [AW-1:0] addr;
  logic [31:0]   wdata, rdata;

  logic        o_full_r;
  logic        o_kind_r;
  logic [31:0] o_val_r;
  logic        o_load;
  logic        o_kind_nxt;
  logic [31:0] o_val_nxt;

  stmc_ram #(.WIDTH(32), .DEPTH(1 << AW)) u_ram (
    .clk(clk), .we(we), .addr(addr), .wdata(wdata), .rdata(rdata)
  );

  // clamp configuration
  always_comb begin
    nm = modes_in_use;
    if (nm < 3'd2) nm = 3'd2;
    if ({29'd0, nm} > CAP) nm = 3'(CAP);
    rk = (RW + 1)'(rank_in_use);
    if (rank_in_use == 5'd0) rk = (RW + 1)'(1);
    if ({27'd0, rank_in_use} > MAX_RANK) rk = (RW + 1)'(MAX_RANK);
  end

  // coordinate of a mode
  function automatic logic [DW-1:0] crd(input stmc_pkg::cmd_t c, input logic [2:0] m);
    logic [9:0] v;
    case (m[1:0])
      2'd0: v = c.coord0;
      2'd1: v = c.coord1;
      2'd2: v = c.coord2;
      default: v = c.coord3;
    endcase
    return DW'(v);
  endfunction

  // next factor mode to multiply, from m onward; returns nm when none left
  function automatic logic [2:0] next_mode(input logic [2:0] m, input logic [2:0] n,
                                           input logic [1:0] t);
    logic [2:0] r;
    r = m;
    if (r < n && r == {1'b0, t}) r = r + 3'd1;
    return r;
  endfunction

  logic signed [33:0] sum;
  logic [RW-1:0] rcol;
  logic [2:0] nxt_m;
  assign rcol = r_r[RW-1:0];
  assign sum = {{2{rdata[31]}}, rdata} + {{2{acc_r[31]}}, acc_r};

  // output register
  assign out_valid = o_full_r;
  assign out_result_kind = o_kind_r;
  assign out_read_value = o_val_r;

  always_comb begin
    st_nxt = st_r;
    m_nxt = m_r;
    r_nxt = r_r;
    acc_nxt = acc_r;
    q_pop = 1'b0;
    we = 1'b0;
    addr = '0;
    wdata = cmd_r.value;
    o_load = 1'b0;
    o_kind_nxt = stmc_pkg::RES_READ;
    o_val_nxt = '0;
    nxt_m = next_mode(m_r, nm, target_mode);
    case (st_r)
      S_IDLE: begin
        if (q_valid && !o_full_r) begin
          q_pop = 1'b1;
          case (q_cmd.kind)
            stmc_pkg::KIND_WRITE: begin
              we = q_cmd.mode_ok;
              addr = {MW'(q_cmd.emode), DW'(q_cmd.erow), RW'(q_cmd.ecol)};
              wdata = q_cmd.value;
            end
            stmc_pkg::KIND_READ: begin
              addr = {MW'(q_cmd.emode), DW'(q_cmd.erow), RW'(q_cmd.ecol)};
              st_nxt = S_RWAIT;
            end
            stmc_pkg::KIND_NZ: begin
              r_nxt = '0;
              m_nxt = '0;
              acc_nxt = q_cmd.value;
              st_nxt = ({30'd0, target_mode} < MAX_MODES) ? S_FRD : S_WB;
            end
            default: st_nxt = S_IDLE;
          endcase
        end
      end
      S_RWAIT: begin
        // keep the element address so the read data stays in place
        addr = {MW'(cmd_r.emode), DW'(cmd_r.erow), RW'(cmd_r.ecol)};
        st_nxt = S_RDATA;
      end
      S_RDATA: begin
        o_load = 1'b1;
        o_val_nxt = cmd_r.mode_ok ? rdata : 32'd0;
        st_nxt = S_IDLE;
      end
      S_FRD: begin
        // issue read of the next factor entry, or of the target entry
        if (nxt_m < nm) begin
          addr = {MW'(nxt_m), crd(cmd_r, nxt_m), rcol};
          m_nxt = nxt_m;
          st_nxt = S_FMUL;
        end else begin
          addr = {MW'(target_mode), crd(cmd_r, {1'b0, target_mode}), rcol};
          st_nxt = S_ACC;
        end
      end
      S_FMUL: st_nxt = S_FSH;
      S_FSH: begin
        acc_nxt = ov ? (prod_r[63] ? 32'h80000000 : 32'h7FFFFFFF) : sh;
        m_nxt = m_r + 3'd1;
        st_nxt = S_FRD;
      end
      S_ACC: begin
        // hold the target address for the write-back cycle
        addr = {MW'(target_mode), crd(cmd_r, {1'b0, target_mode}), rcol};
        st_nxt = S_WB;
      end
      S_WB: begin
        if ({30'd0, target_mode} < MAX_MODES && r_r < rk) begin
          addr = {MW'(target_mode), crd(cmd_r, {1'b0, target_mode}), rcol};
          we = 1'b1;
          wdata = stmc_pkg::sat34(sum);
        end
        if ({30'd0, target_mode} < MAX_MODES && r_r + 1'b1 < rk) begin
          r_nxt = r_r + 1'b1;
          m_nxt = '0;
          acc_nxt = cmd_r.value;
          st_nxt = S_FRD;
        end else begin
          st_nxt = S_IDLE;
          if (cmd_r.last) begin
            o_load = 1'b1;
            o_kind_nxt = stmc_pkg::RES_DONE;
          end
        end
      end
      default: st_nxt = S_IDLE;
    endcase
  end

  // multiply, then shift with saturation in the next stage
  assign p_hi = prod_r >>> 16;
  assign sh = p_hi[31:0];
  assign ov = (p_hi[63:31] != '0) && (p_hi[63:31] != '1);

  always_ff @(posedge clk) begin
    prod_r <= $signed(acc_r) * $signed(rdata);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= S_IDLE;
      o_full_r <= 1'b0;
    end else begin
      st_r <= st_nxt;
      if (o_load) o_full_r <= 1'b1;
      else if (out_ready) o_full_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) cmd_r <= q_cmd;
    m_r <= m_nxt;
    r_r <= r_nxt;
    acc_r <= acc_nxt;
    if (o_load) begin
      o_kind_r <= o_kind_nxt;
      o_val_r <= o_val_nxt;
    end
  end
endmodule

@@ hdl/sparse_tensor_mttkrp_coo.sv @@
// top level of the coo mttkrp engine
// A nonzero item leaves the queue in the idle state, then for each rank
// column steps through the read, multiply and shift states for each factor
// mode and then the target read, hold and write-back states, over
// rank_in_use columns, set by the single multiplier lane and the one port of the factor store.
// Write items finish in the idle state; read items pass through the idle,
// wait and data states. A two-entry command queue lets the input keep accepting
// items while the back end works, and an output register holds a result until it is taken.
module sparse_tensor_mttkrp_coo #(
  parameter int MAX_MODES = 4,
  parameter int MAX_RANK = 16,
  parameter int MAX_DIM = 1024
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_we,
  input  logic [1:0]         cfg_index,
  input  logic [4:0]         cfg_data,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [1:0]         in_kind,
  input  logic signed [31:0] in_value,
  input  logic [9:0]         in_coord_0,
  input  logic [9:0]         in_coord_1,
  input  logic [9:0]         in_coord_2,
  input  logic [9:0]         in_coord_3,
  input  logic               in_last_nonzero,
  input  logic [1:0]         in_elem_mode,
  input  logic [9:0]         in_elem_row,
  input  logic [3:0]         in_elem_col,
  output logic               out_valid,
  input  logic               out_ready,
  output logic               out_result_kind,
  output logic signed [31:0] out_read_value
);
  logic [2:0] modes_r;
  logic [4:0] rank_r;
  logic [1:0] target_r;
  stmc_pkg::cmd_t in_cmd, q_cmd;
  logic q_valid, q_pop;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      modes_r <= 3'd3;
      rank_r <= 5'd16;
      target_r <= 2'd0;
    end else if (cfg_we) begin
      case (cfg_index)
        stmc_pkg::REG_MODES:  modes_r <= cfg_data[2:0];
        stmc_pkg::REG_RANK:   rank_r <= cfg_data;
        stmc_pkg::REG_TARGET: target_r <= cfg_data[1:0];
        default: ;
      endcase
    end
  end

  // gather the item fields, rows reduced modulo the matrix height
  always_comb begin
    in_cmd.kind = in_kind;
    in_cmd.value = in_value;
    in_cmd.coord0 = in_coord_0 & 10'(MAX_DIM - 1);
    in_cmd.coord1 = in_coord_1 & 10'(MAX_DIM - 1);
    in_cmd.coord2 = in_coord_2 & 10'(MAX_DIM - 1);
    in_cmd.coord3 = in_coord_3 & 10'(MAX_DIM - 1);
    in_cmd.last = in_last_nonzero;
    in_cmd.mode_ok = 1'b0;
    in_cmd.emode = in_elem_mode;
    in_cmd.erow = in_elem_row & 10'(MAX_DIM - 1);
    in_cmd.ecol = in_elem_col & 4'(MAX_RANK - 1);
  end

  stmc_front #(.MAX_MODES(MAX_MODES), .DEPTH(2)) u_front (
    .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_ready(in_ready),
    .in_cmd(in_cmd), .q_valid(q_valid), .q_pop(q_pop), .q_cmd(q_cmd)
  );

  stmc_back #(.MAX_MODES(MAX_MODES), .MAX_RANK(MAX_RANK), .MAX_DIM(MAX_DIM)) u_back (
    .clk(clk), .rst_n(rst_n), .q_valid(q_valid), .q_pop(q_pop), .q_cmd(q_cmd),
    .modes_in_use(modes_r), .rank_in_use(rank_r), .target_mode(target_r),
    .out_valid(out_valid), .out_ready(out_ready),
    .out_result_kind(out_result_kind), .out_read_value(out_read_value)
  );
endmodule

@@ tb/mttkrp_checker.sv @@
// checker for the coo mttkrp engine: tracks the factor store, predicts and compares results
`timescale 1ns / 1ps
module mttkrp_checker (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_we,
  input  logic [1:0]         cfg_index,
  input  logic [4:0]         cfg_data,
  input  logic               in_valid,
  input  logic               in_ready,
  input  logic [1:0]         in_kind,
  input  logic signed [31:0] in_value,
  input  logic [9:0]         in_coord_0,
  input  logic [9:0]         in_coord_1,
  input  logic [9:0]         in_coord_2,
  input  logic [9:0]         in_coord_3,
  input  logic               in_last_nonzero,
  input  logic [1:0]         in_elem_mode,
  input  logic [9:0]         in_elem_row,
  input  logic [3:0]         in_elem_col,
  input  logic               out_valid,
  input  logic               out_ready,
  input  logic               out_result_kind,
  input  logic signed [31:0] out_read_value,
  output int                 fail_count,
  output int                 pending_count
);

  typedef struct packed {
    logic        kind;
    logic [31:0] value;
  } result_t;

  logic [31:0] factor_mem [0:65535];
  logic [2:0]  modes_reg;
  logic [4:0]  rank_reg;
  logic [1:0]  target_reg;
  result_t     expected_q[$];

  assign pending_count = expected_q.size();

  // saturate a 64-bit value to 32-bit signed
  function automatic logic signed [31:0] clamp32(input logic signed [63:0] v);
    if (v > 64'sh7FFFFFFF) return 32'sh7FFFFFFF;
    if (v < -64'sh80000000) return 32'sh80000000;
    return v[31:0];
  endfunction

  // q16.16 product, floor shift, then saturation
  function automatic logic signed [31:0] fx_mul(input logic signed [31:0] a,
                                                input logic signed [31:0] b);
    logic signed [63:0] p;
    p = 64'(a) * 64'(b);
    return clamp32(p >>> 16);
  endfunction

  function automatic int word_of(input int m, input int row, input int col);
    return (m * 1024 + row) * 16 + col;
  endfunction

  // apply one accepted item to the store and queue any result
  task automatic apply_item();
    int nm, rk, r, m, trow, a;
    int crd[4];
    logic signed [31:0] acc;
    result_t res;
    crd[0] = in_coord_0; crd[1] = in_coord_1;
    crd[2] = in_coord_2; crd[3] = in_coord_3;
    case (in_kind)
      stmc_pkg::KIND_WRITE:
        factor_mem[word_of(in_elem_mode, in_elem_row, in_elem_col)] = in_value;
      stmc_pkg::KIND_READ: begin
        res.kind = stmc_pkg::RES_READ;
        res.value = factor_mem[word_of(in_elem_mode, in_elem_row, in_elem_col)];
        expected_q.push_back(res);
      end
      stmc_pkg::KIND_NZ: begin
        nm = modes_reg < 2 ? 2 : (modes_reg > 4 ? 4 : modes_reg);
        rk = rank_reg < 1 ? 1 : (rank_reg > 16 ? 16 : rank_reg);
        trow = crd[target_reg];
        for (r = 0; r < rk; r++) begin
          acc = in_value;
          for (m = 0; m < nm; m++)
            if (m != target_reg) acc = fx_mul(acc, factor_mem[word_of(m, crd[m], r)]);
          a = word_of(target_reg, trow, r);
          factor_mem[a] = clamp32(64'(signed'(factor_mem[a])) + 64'(acc));
        end
        if (in_last_nonzero) begin
          res.kind = stmc_pkg::RES_DONE;
          res.value = '0;
          expected_q.push_back(res);
        end
      end
      default: ;
    endcase
  endtask

  // watch both channels and the register port
  always @(posedge clk) begin
    result_t exp_r;
    if (!rst_n) begin
      modes_reg <= 3'd3;
      rank_reg <= 5'd16;
      target_reg <= 2'd0;
      fail_count <= 0;
      expected_q.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          stmc_pkg::REG_MODES:  modes_reg <= cfg_data[2:0];
          stmc_pkg::REG_RANK:   rank_reg <= cfg_data;
          stmc_pkg::REG_TARGET: target_reg <= cfg_data[1:0];
          default: ;
        endcase
      end
      if (out_valid && out_ready) begin
        if (expected_q.size() == 0) begin
          $display("%0t: unexpected result kind %0d value %h", $time,
                   out_result_kind, out_read_value);
          fail_count <= fail_count + 1;
        end else begin
          exp_r = expected_q.pop_front();
          if (exp_r.kind !== out_result_kind || exp_r.value !== out_read_value) begin
            $display("%0t: mismatch expected kind %0d value %h, got kind %0d value %h",
                     $time, exp_r.kind, exp_r.value, out_result_kind, out_read_value);
            fail_count <= fail_count + 1;
          end
        end
      end
      if (in_valid && in_ready) apply_item();
    end
  end

endmodule

@@ tb/testbench.sv @@
// stimulus and verdict for the coo mttkrp engine
`timescale 1ns / 1ps
module testbench;

  logic clk = 0, rst_n = 0;
  logic cfg_we = 0;
  logic [1:0] cfg_index = '0;
  logic [4:0] cfg_data = '0;
  logic in_valid = 0, in_ready;
  logic [1:0] in_kind = '0;
  logic signed [31:0] in_value = '0;
  logic [9:0] in_coord_0 = '0, in_coord_1 = '0, in_coord_2 = '0, in_coord_3 = '0;
  logic in_last_nonzero = 0;
  logic [1:0] in_elem_mode = '0;
  logic [9:0] in_elem_row = '0;
  logic [3:0] in_elem_col = '0;
  logic out_valid, out_ready = 0;
  logic out_result_kind;
  logic signed [31:0] out_read_value;
  int fail_count, pending_count;
  int send_idle = 0, recv_idle = 0;
  longint cycle_count = 0;

  // small row set so nonzeros hit written rows and reads hit accumulated ones
  localparam int ROWS = 4;

  sparse_tensor_mttkrp_coo i_dut (.*);

  mttkrp_checker i_checker (.*);

  initial forever #5 clk = ~clk;

  // watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > 3000000) begin
      $display("testbench failed");
      $finish;
    end
  end

  // receiver stall
  always @(posedge clk) out_ready <= ($urandom_range(99) >= recv_idle);

  // one register write; the caller drops the enable after its last write
  task automatic cfg_write(input logic [1:0] idx, input logic [4:0] d);
    cfg_we <= 1; cfg_index <= idx; cfg_data <= d;
    @(posedge clk);
  endtask

  // send one item and wait for acceptance; valid drops only while idling
  task automatic send(input logic [1:0] k, input logic [31:0] v, input logic [9:0] c0,
                      input logic [9:0] c1, input logic [9:0] c2, input logic [9:0] c3,
                      input logic lst, input logic [1:0] em, input logic [9:0] er,
                      input logic [3:0] ec);
    while ($urandom_range(99) < send_idle) begin
      in_valid <= 0;
      @(posedge clk);
    end
    in_valid <= 1; in_kind <= k; in_value <= v;
    in_coord_0 <= c0; in_coord_1 <= c1; in_coord_2 <= c2; in_coord_3 <= c3;
    in_last_nonzero <= lst; in_elem_mode <= em; in_elem_row <= er; in_elem_col <= ec;
    do @(posedge clk); while (!in_ready);
  endtask

  function automatic logic [31:0] rand_q();
    case ($urandom_range(4))
      0: return 32'h7FFFFFFF;
      1: return 32'h80000000;
      2: return $urandom;
      default: return $urandom_range(131072) - 65536;
    endcase
  endfunction

  // write every element of rows 0..ROWS-1 in all four matrices
  task automatic load_store(input logic [1:0] tgt);
    for (int m = 0; m < 4; m++)
      for (int r = 0; r < ROWS; r++)
        for (int c = 0; c < 16; c++)
          send(stmc_pkg::KIND_WRITE, (m == tgt) ? 32'h0 : rand_q(), 10'd0, 10'd0,
               10'd0, 10'd0, 1'b0, 2'(m), 10'(r), 4'(c));
  endtask

  task automatic wait_idle();
    in_valid <= 0;
    while (pending_count != 0) @(posedge clk);
    repeat (600) @(posedge clk);
  endtask

  // one phase: a random mix of nonzeros, reads, writes and unused kinds, then a last-flagged nonzero
  task automatic run_phase(input int n);
    int k;
    logic [1:0] em;
    for (int i = 0; i < n; i++) begin
      k = $urandom_range(9);
      em = 2'($urandom_range(3));
      if (k < 6)
        send(stmc_pkg::KIND_NZ, rand_q(), 10'($urandom_range(ROWS - 1)),
             10'($urandom_range(ROWS - 1)), 10'($urandom_range(ROWS - 1)),
             10'($urandom_range(ROWS - 1)), $urandom_range(7) == 0,
             2'($urandom), 10'($urandom), 4'($urandom));
      else if (k < 8)
        send(stmc_pkg::KIND_READ, $urandom, 10'($urandom), 10'($urandom),
             10'($urandom), 10'($urandom), 1'($urandom),
             em, 10'($urandom_range(ROWS - 1)), 4'($urandom));
      else if (k < 9)
        send(stmc_pkg::KIND_WRITE, rand_q(), 10'($urandom), 10'($urandom),
             10'($urandom), 10'($urandom), 1'($urandom),
             em, 10'($urandom_range(ROWS - 1)), 4'($urandom));
      else
        send(2'd3, $urandom, 10'($urandom), 10'($urandom), 10'($urandom),
             10'($urandom), 1'($urandom), 2'($urandom), 10'($urandom), 4'($urandom));
    end
    send(stmc_pkg::KIND_NZ, rand_q(), 10'd0, 10'd1, 10'd2, 10'd3, 1'b1, 2'd0, 10'd0, 4'd0);
  endtask

  initial begin
    repeat (8) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);
    // directed: reset settings, extremes of values, last flag, unused kind
    load_store(2'd0);
    send(stmc_pkg::KIND_NZ, 32'h7FFFFFFF, 10'd0, 10'd1, 10'd2, 10'd3, 1'b0,
         2'd0, 10'd0, 4'd0);
    send(stmc_pkg::KIND_NZ, 32'h80000000, 10'd3, 10'd3, 10'd3, 10'd3, 1'b0,
         2'd3, 10'd1023, 4'd15);
    send(stmc_pkg::KIND_NZ, 32'h00010000, 10'd1, 10'd0, 10'd3, 10'd2, 1'b1,
         2'd0, 10'd0, 4'd0);
    send(2'd3, 32'hFFFFFFFF, 10'd1023, 10'd1023, 10'd1023, 10'd1023, 1'b1,
         2'd3, 10'd1023, 4'd15);
    send(stmc_pkg::KIND_READ, 32'd0, 10'd0, 10'd0, 10'd0, 10'd0, 1'b0, 2'd0, 10'd0, 4'd0);
    send(stmc_pkg::KIND_READ, 32'd0, 10'd0, 10'd0, 10'd0, 10'd0, 1'b0, 2'd0, 10'd3, 4'd15);
    send(stmc_pkg::KIND_READ, 32'd0, 10'd0, 10'd0, 10'd0, 10'd0, 1'b0, 2'd3, 10'd3, 4'd15);
    send(stmc_pkg::KIND_WRITE, 32'hFFFFFFFF, 10'd0, 10'd0, 10'd0, 10'd0, 1'b0,
         2'd3, 10'd3, 4'd15);
    send(stmc_pkg::KIND_READ, 32'd0, 10'd0, 10'd0, 10'd0, 10'd0, 1'b0, 2'd3, 10'd3, 4'd15);
    // settings sweep across idling regimes
    for (int p = 0; p < 9; p++) begin
      if (p < 3) begin send_idle = 20; recv_idle = 66; end
      else if (p < 6) begin send_idle = 66; recv_idle = 20; end
      else begin send_idle = 0; recv_idle = 0; end
      wait_idle();
      case (p % 3)
        0: begin cfg_write(stmc_pkg::REG_MODES, 5'd2); cfg_write(stmc_pkg::REG_RANK, 5'd1);
                 cfg_write(stmc_pkg::REG_TARGET, 5'd1); end
        1: begin cfg_write(stmc_pkg::REG_MODES, 5'd4); cfg_write(stmc_pkg::REG_RANK, 5'd16);
                 cfg_write(stmc_pkg::REG_TARGET, 5'd3); end
        default: begin cfg_write(stmc_pkg::REG_MODES, 5'($urandom_range(2, 4)));
                 cfg_write(stmc_pkg::REG_RANK, 5'($urandom_range(1, 16)));
                 cfg_write(stmc_pkg::REG_TARGET, 5'($urandom_range(3))); end
      endcase
      if (p == 4) begin
        cfg_write(stmc_pkg::REG_MODES, 5'd3);
        cfg_write(stmc_pkg::REG_TARGET, 5'd3);
      end
      cfg_we <= 0;
      run_phase(85);
    end
    wait_idle();
    if (fail_count == 0)
      $display("testbench passed");
    else
      $display("testbench failed");
    $finish;
  end

endmodule

@@ files.f @@
hdl/stmc_pkg.sv
hdl/stmc_ram.sv
hdl/stmc_front.sv
hdl/stmc_back.sv
hdl/sparse_tensor_mttkrp_coo.sv
tb/mttkrp_checker.sv
tb/testbench.sv
